### sv/bale_pkg.sv
package bale_pkg;

    // List geometry
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths of a transaction
    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 4;
    localparam int COUNT_W  = 5;

    // Operation codes
    localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
    localparam logic [OP_W-1:0] OP_SORT   = 3'd3;
    localparam logic [OP_W-1:0] OP_LIST   = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd3;

    typedef logic signed [VALUE_W-1:0] entry_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        entry_t           value;
        logic [POS_W-1:0] position;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  index;
        entry_t              entry_value;
        logic [COUNT_W-1:0]  count;
        logic                last;
    } out_item_t;

    // What one cell does in a cycle
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_LEFT,
        CELL_RIGHT,
        CELL_HEAD,
        CELL_MIN,
        CELL_MAX
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
    } cell_ctrl_t;

endpackage

### sv/bale_cell.sv
module bale_cell (
    input  logic                clk,
    input  bale_pkg::cell_ctrl_t ctrl,
    input  bale_pkg::entry_t    load_value,
    input  bale_pkg::entry_t    left,
    input  bale_pkg::entry_t    right,
    input  bale_pkg::entry_t    head,
    output bale_pkg::entry_t    data
);

    bale_pkg::entry_t data_reg;
    bale_pkg::entry_t data_next;

    // Pick the next entry: hold, load, shift from a neighbor, copy the head, or compare-exchange
    always_comb
    begin
        unique case (ctrl.op)
            bale_pkg::CELL_HOLD:  data_next = data_reg;
            bale_pkg::CELL_LOAD:  data_next = load_value;
            bale_pkg::CELL_LEFT:  data_next = left;
            bale_pkg::CELL_RIGHT: data_next = right;
            bale_pkg::CELL_HEAD:  data_next = head;
            bale_pkg::CELL_MIN:   data_next = (right < data_reg) ? right : data_reg;
            bale_pkg::CELL_MAX:   data_next = (data_reg < left) ? left : data_reg;
            default:              data_next = data_reg;
        endcase
    end

    // Hold the entry; contents are undefined until written
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

### sv/bounded_array_list_engine.sv
// Channel  | Ports                 | Transfer
// ---------+-----------------------+------------------------------------------
// command  | start, busy, item     | taken at a clock edge with start & !busy
// result   | strobe, result        | shown for one cycle, taken at its end
//
// Append, insert at front and remove shift the chain of cells in place;
// the result shows the next cycle, when busy is low.
// Sort runs CAPACITY odd-even transposition phases over the cells, then
// gives one result. List rotates the occupied cells one place a cycle and
// gives one result a cycle, count results in all.
// Reset clears the count and the controller; entries need no reset.
// The receiver cannot stall: results are never held back.
module bounded_array_list_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  bale_pkg::in_item_t   item,
    output logic                 strobe,
    output bale_pkg::out_item_t  result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SORT,
        S_LIST
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    logic [bale_pkg::CNT_W-1:0]     count_reg;
    logic [bale_pkg::CNT_W-1:0]     count_next;
    logic [bale_pkg::IDX_W-1:0]     step_reg;
    logic [bale_pkg::IDX_W-1:0]     step_next;
    logic                           strobe_reg;
    logic                           strobe_next;
    bale_pkg::out_item_t            result_reg;
    bale_pkg::out_item_t            result_next;

    bale_pkg::cell_ctrl_t           ctrl   [bale_pkg::CAPACITY];
    bale_pkg::entry_t               data   [bale_pkg::CAPACITY];

    logic                           accept;
    logic                           full;
    logic                           empty;
    logic                           pos_bad;
    logic [bale_pkg::CNT_W-1:0]     pos_ext;
    logic                           step_last;

    assign accept    = start && (state_reg == S_IDLE);
    assign full      = (count_reg >= bale_pkg::CNT_W'(bale_pkg::CAPACITY));
    assign empty     = (count_reg == '0);
    assign pos_ext   = bale_pkg::CNT_W'(item.position);
    assign pos_bad   = (pos_ext >= count_reg);
    assign step_last = (step_reg == bale_pkg::IDX_W'(bale_pkg::CAPACITY - 1));

    // Build the row of cells
    for (genvar g = 0; g < bale_pkg::CAPACITY; g++)
    begin : g_cell
        bale_pkg::entry_t left_in;
        bale_pkg::entry_t right_in;

        if (g == 0)
        begin : g_first
            assign left_in = item.value;
        end
        else
        begin : g_inner_l
            assign left_in = data[g-1];
        end

        if (g == bale_pkg::CAPACITY - 1)
        begin : g_end
            assign right_in = data[g];
        end
        else
        begin : g_inner_r
            assign right_in = data[g+1];
        end

        bale_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl[g]),
            .load_value (item.value),
            .left       (left_in),
            .right      (right_in),
            .head       (data[0]),
            .data       (data[g])
        );
    end

    // Steer each cell for the current cycle
    always_comb
    begin
        for (int i = 0; i < bale_pkg::CAPACITY; i++)
        begin
            ctrl[i].op = bale_pkg::CELL_HOLD;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (item.op == bale_pkg::OP_APPEND && !full
                            && bale_pkg::CNT_W'(i) == count_reg)
                            ctrl[i].op = bale_pkg::CELL_LOAD;
                        else if (item.op == bale_pkg::OP_INSERT && !full)
                            ctrl[i].op = (i == 0) ? bale_pkg::CELL_LOAD
                                                  : bale_pkg::CELL_LEFT;
                        else if (item.op == bale_pkg::OP_REMOVE && !empty && !pos_bad
                                 && bale_pkg::CNT_W'(i) >= pos_ext)
                            ctrl[i].op = bale_pkg::CELL_RIGHT;
                    end
                end
                S_SORT:
                begin
                    // Lower cell of an active pair keeps the min, upper the max
                    if (1'(i) == step_reg[0])
                    begin
                        if (bale_pkg::CNT_W'(i + 1) < count_reg)
                            ctrl[i].op = bale_pkg::CELL_MIN;
                    end
                    else if (i >= 1 && bale_pkg::CNT_W'(i) < count_reg)
                        ctrl[i].op = bale_pkg::CELL_MAX;
                end
                S_LIST:
                begin
                    // Rotate the occupied cells toward the head
                    if (bale_pkg::CNT_W'(i + 1) < count_reg)
                        ctrl[i].op = bale_pkg::CELL_RIGHT;
                    else if (bale_pkg::CNT_W'(i + 1) == count_reg)
                        ctrl[i].op = bale_pkg::CELL_HEAD;
                end
                default:
                    ctrl[i].op = bale_pkg::CELL_HOLD;
            endcase
        end
    end

    // Sequence operations and form results
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        step_next   = step_reg;
        strobe_next = 1'b0;
        result_next = result_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    result_next.status      = bale_pkg::ST_OK;
                    result_next.index       = '0;
                    result_next.entry_value = '0;
                    result_next.last        = 1'b1;
                    step_next               = '0;
                    unique case (item.op)
                        bale_pkg::OP_APPEND,
                        bale_pkg::OP_INSERT:
                        begin
                            strobe_next = 1'b1;
                            if (full)
                                result_next.status = bale_pkg::ST_FULL;
                            else
                            begin
                                count_next              = count_reg + 1'b1;
                                result_next.entry_value = item.value;
                                if (item.op == bale_pkg::OP_APPEND)
                                    result_next.index =
                                        bale_pkg::INDEX_W'(count_reg);
                            end
                        end
                        bale_pkg::OP_REMOVE:
                        begin
                            strobe_next = 1'b1;
                            if (empty)
                                result_next.status = bale_pkg::ST_EMPTY;
                            else if (pos_bad)
                            begin
                                result_next.status = bale_pkg::ST_BAD_POS;
                                result_next.index  =
                                    bale_pkg::INDEX_W'(item.position);
                            end
                            else
                            begin
                                count_next              = count_reg - 1'b1;
                                result_next.index       =
                                    bale_pkg::INDEX_W'(item.position);
                                result_next.entry_value =
                                    data[bale_pkg::IDX_W'(item.position)];
                            end
                        end
                        bale_pkg::OP_SORT:
                            state_next = S_SORT;
                        bale_pkg::OP_LIST:
                        begin
                            if (empty)
                            begin
                                strobe_next        = 1'b1;
                                result_next.status = bale_pkg::ST_EMPTY;
                            end
                            else
                                state_next = S_LIST;
                        end
                        default:
                            state_next = S_IDLE;
                    endcase
                    result_next.count = bale_pkg::COUNT_W'(count_next);
                end
            end
            S_SORT:
            begin
                step_next = step_reg + 1'b1;
                if (step_last)
                begin
                    state_next              = S_IDLE;
                    strobe_next             = 1'b1;
                    result_next.status      = bale_pkg::ST_OK;
                    result_next.index       = '0;
                    result_next.entry_value = '0;
                    result_next.count       = bale_pkg::COUNT_W'(count_reg);
                    result_next.last        = 1'b1;
                end
            end
            S_LIST:
            begin
                step_next               = step_reg + 1'b1;
                strobe_next             = 1'b1;
                result_next.status      = bale_pkg::ST_OK;
                result_next.index       = bale_pkg::INDEX_W'(step_reg);
                result_next.entry_value = data[0];
                result_next.count       = bale_pkg::COUNT_W'(count_reg);
                result_next.last        =
                    (bale_pkg::CNT_W'(step_reg) == count_reg - 1'b1);
                if (result_next.last)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Hold state, count, step, strobe and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            step_reg   <= '0;
            strobe_reg <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            step_reg   <= step_next;
            strobe_reg <= strobe_next;
            result_reg <= result_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule
